@@ rtl/bpcs_pkg.sv @@
// Shared types and constants of the barometer compensation and smoothing core.
`timescale 1ns / 1ps
`default_nettype none

package bpcs_pkg;

   // Field widths.
   localparam int IN_W     = 24;
   localparam int ADC_BITS = 24;
   localparam int COEF_W   = 16;
   localparam int WARM_W   = 8;
   localparam int PRESS_W  = 17;
   localparam int TEMP_W   = 15;

   // Internal arithmetic widths.
   localparam int DT_W     = IN_W + 1;
   localparam int PROD_W   = 60;
   localparam int MPLIER_W = IN_W;
   localparam int OFF_W    = 36;
   localparam int SENS_W   = 35;
   localparam int P_W      = 24;
   localparam int TSUM_W   = 24;

   // Stream packing.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_IDX_W  = 3;

   localparam logic [IN_W-1:0] ADC_MASK = IN_W'((64'd1 << ADC_BITS) - 64'd1);

   // Compensation constants.
   localparam int SH_TEMP  = 23;
   localparam int SH_OFF   = 7;
   localparam int SH_SENS  = 8;
   localparam int SH_PRESS = 21;
   localparam int SH_FINAL = 15;

   localparam logic signed [TSUM_W-1:0] TEMP_BASE = 24'sd2000;
   localparam logic signed [TSUM_W-1:0] TEMP_MIN  = -24'sd4000;
   localparam logic signed [TSUM_W-1:0] TEMP_MAX  = 24'sd8500;
   localparam logic [PRESS_W-1:0]       PRESS_MAX = 17'd131071;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SENS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OFFSET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SENS_TC   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_OFFSET_TC = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TREF      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TSENS     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP         = 3'd6;

   // Register reset values.
   localparam logic [COEF_W-1:0] RST_COEF_SENS      = 16'd40127;
   localparam logic [COEF_W-1:0] RST_COEF_OFFSET    = 16'd36924;
   localparam logic [COEF_W-1:0] RST_COEF_SENS_TC   = 16'd23317;
   localparam logic [COEF_W-1:0] RST_COEF_OFFSET_TC = 16'd23282;
   localparam logic [COEF_W-1:0] RST_COEF_TREF      = 16'd33464;
   localparam logic [COEF_W-1:0] RST_COEF_TSENS     = 16'd28312;
   localparam logic [WARM_W-1:0] RST_WARMUP         = 8'd50;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEMP,
      ST_OFF,
      ST_SENS,
      ST_PRESS,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                     start;
      logic signed [PROD_W-1:0] mcand;
      logic [MPLIER_W-1:0]      mplier;
   } mul_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [PROD_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic               settled;
      logic [PRESS_W-1:0] start;
      logic [PRESS_W-1:0] smooth;
      logic [PRESS_W-1:0] comp;
   } smooth_out_type;

endpackage

`default_nettype wire

@@ rtl/bpcs_serial_mul.sv @@
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
`timescale 1ns / 1ps
`default_nettype none

module bpcs_serial_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bpcs_pkg::mul_req_type mul_req,
   output bpcs_pkg::mul_rsp_type     mul_rsp
);

   logic                               busy_ff, busy_in;
   logic signed [bpcs_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic signed [bpcs_pkg::PROD_W-1:0] mcand_ff, mcand_in;
   logic [bpcs_pkg::MPLIER_W-1:0]      mplier_ff, mplier_in;

   // The product is complete once every set multiplier bit has been consumed.
   assign mul_rsp.busy = busy_ff;
   assign mul_rsp.done = busy_ff && (mplier_ff == '0);
   assign mul_rsp.prod = acc_ff;

   always_comb begin
      busy_in   = busy_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (mul_req.start) begin
         busy_in   = 1'b1;
         acc_in    = '0;
         mcand_in  = mul_req.mcand;
         mplier_in = mul_req.mplier;
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

endmodule

`default_nettype wire

@@ rtl/bpcs_smooth.sv @@
// Pressure saturation, quarter-weight smoothing and warm-up tracking.
`timescale 1ns / 1ps
`default_nettype none

module bpcs_smooth (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               load,
   input  wire logic signed [bpcs_pkg::P_W-1:0]    press,
   input  wire logic [bpcs_pkg::WARM_W-1:0]        warmup_samples,
   output bpcs_pkg::smooth_out_type                smooth_out
);

   logic [bpcs_pkg::PRESS_W-1:0] smooth_ff, smooth_in;
   logic [bpcs_pkg::PRESS_W-1:0] start_ff, start_in;
   logic [bpcs_pkg::WARM_W-1:0]  warm_ff, warm_in;
   logic                         done_ff, done_in;
   logic [bpcs_pkg::PRESS_W-1:0] comp;
   logic [bpcs_pkg::PRESS_W+1:0] filt_sum;

   always_comb begin
      priority if (press < 0) begin
         comp = '0;
      end else if (press > signed'(bpcs_pkg::P_W'(bpcs_pkg::PRESS_MAX))) begin
         comp = bpcs_pkg::PRESS_MAX;
      end else begin
         comp = press[bpcs_pkg::PRESS_W-1:0];
      end

      // new + 3 * old, then divided by four.
      filt_sum = {2'b00, comp} + {1'b0, smooth_ff, 1'b0} + {2'b00, smooth_ff};

      smooth_in = smooth_ff;
      start_in  = start_ff;
      warm_in   = warm_ff;
      done_in   = done_ff;
      if (!done_ff && (warm_ff < warmup_samples)) begin
         warm_in   = warm_ff + 1'b1;
         smooth_in = comp;
         start_in  = comp;
      end else begin
         done_in   = 1'b1;
         smooth_in = filt_sum[bpcs_pkg::PRESS_W+1:2];
      end

      smooth_out.comp    = comp;
      smooth_out.smooth  = smooth_in;
      smooth_out.start   = start_in;
      smooth_out.settled = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
         start_ff  <= '0;
         warm_ff   <= '0;
         done_ff   <= 1'b0;
      end else if (load) begin
         smooth_ff <= smooth_in;
         start_ff  <= start_in;
         warm_ff   <= warm_in;
         done_ff   <= done_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/baro_pressure_compensate_smooth_core.sv @@
// Top level of the barometer compensation and smoothing core.
//
// Each item carries one raw pressure and temperature conversion pair and
// yields one result: compensated pressure, smoothed pressure, start
// reference, temperature in 0.01 degC and the settled flag. All four
// products of the compensation go through one bit-serial shift-add
// multiplier that consumes one multiplier bit per cycle and stops as soon
// as the remaining multiplier bits are zero, so an item finishes sooner
// when the top bits of the coefficients or of the raw pressure are zero.
// A result that is still waiting in the output register holds the next
// one back until it is taken. A new item is taken as soon as the
// previous result has moved into the output register, even if that result
// is still waiting to be taken. Configuration writes are always ready and
// should be issued only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_compensate_smooth_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Bits from low: pressure_raw[23:0], temperature_raw[47:24].
   input  wire logic [bpcs_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // Bits from low: pressure_comp[16:0], pressure_smooth[33:17],
   // pressure_start[50:34], temp_centi[65:51], settled[66], zero fill.
   output logic [bpcs_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [bpcs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bpcs_pkg::COEF_W-1:0]          csr_data
);

   localparam int IN_W   = bpcs_pkg::IN_W;
   localparam int DT_W   = bpcs_pkg::DT_W;
   localparam int PROD_W = bpcs_pkg::PROD_W;
   localparam int COEF_W = bpcs_pkg::COEF_W;

   // Configuration registers.
   logic [COEF_W-1:0]           c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   logic [bpcs_pkg::WARM_W-1:0] warmup_ff;

   bpcs_pkg::state_type               state_ff, state_in;
   logic [IN_W-1:0]                   d1_ff, d1_in;
   logic signed [DT_W-1:0]            dt_ff, dt_in;
   logic signed [bpcs_pkg::TEMP_W-1:0] temp_ff, temp_in;
   logic signed [bpcs_pkg::OFF_W-1:0] off_ff, off_in;
   logic signed [bpcs_pkg::P_W-1:0]   p_ff, p_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bpcs_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [IN_W-1:0]                   d1_raw, d2_raw;
   logic signed [DT_W-1:0]            dt_calc;
   logic signed [bpcs_pkg::TSUM_W-1:0] temp_sum;
   logic signed [bpcs_pkg::SENS_W-1:0] sens_calc;
   logic signed [PROD_W-1:0]          p_wide;
   logic                              req_accept;
   logic                              out_load;

   bpcs_pkg::mul_req_type    mul_req;
   bpcs_pkg::mul_rsp_type    mul_rsp;
   bpcs_pkg::smooth_out_type smooth_out;

   bpcs_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   bpcs_smooth u_smooth (
      .clock          (clock),
      .reset          (reset),
      .load           (out_load),
      .press          (p_ff),
      .warmup_samples (warmup_ff),
      .smooth_out     (smooth_out)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == bpcs_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff     <= bpcs_pkg::RST_COEF_SENS;
         c2_ff     <= bpcs_pkg::RST_COEF_OFFSET;
         c3_ff     <= bpcs_pkg::RST_COEF_SENS_TC;
         c4_ff     <= bpcs_pkg::RST_COEF_OFFSET_TC;
         c5_ff     <= bpcs_pkg::RST_COEF_TREF;
         c6_ff     <= bpcs_pkg::RST_COEF_TSENS;
         warmup_ff <= bpcs_pkg::RST_WARMUP;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bpcs_pkg::CSR_COEF_SENS:      c1_ff <= csr_data;
            bpcs_pkg::CSR_COEF_OFFSET:    c2_ff <= csr_data;
            bpcs_pkg::CSR_COEF_SENS_TC:   c3_ff <= csr_data;
            bpcs_pkg::CSR_COEF_OFFSET_TC: c4_ff <= csr_data;
            bpcs_pkg::CSR_COEF_TREF:      c5_ff <= csr_data;
            bpcs_pkg::CSR_COEF_TSENS:     c6_ff <= csr_data;
            bpcs_pkg::CSR_WARMUP:         warmup_ff <= csr_data[bpcs_pkg::WARM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      d1_raw  = req_tdata[IN_W-1:0] & bpcs_pkg::ADC_MASK;
      d2_raw  = req_tdata[2*IN_W-1:IN_W] & bpcs_pkg::ADC_MASK;
      dt_calc = signed'({1'b0, d2_raw}) - signed'({1'b0, c5_ff, 8'd0});

      // Every arithmetic right shift below is a floor division.
      temp_sum  = bpcs_pkg::TSUM_W'(mul_rsp.prod >>> bpcs_pkg::SH_TEMP) + bpcs_pkg::TEMP_BASE;
      sens_calc = bpcs_pkg::SENS_W'(signed'({1'b0, c1_ff, 15'd0}))
                + bpcs_pkg::SENS_W'(mul_rsp.prod >>> bpcs_pkg::SH_SENS);
      p_wide    = (mul_rsp.prod >>> bpcs_pkg::SH_PRESS) - PROD_W'(off_ff);

      state_in     = state_ff;
      d1_in        = d1_ff;
      dt_in        = dt_ff;
      temp_in      = temp_ff;
      off_in       = off_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      out_load     = 1'b0;
      mul_req.start  = 1'b0;
      mul_req.mcand  = PROD_W'(dt_ff);
      mul_req.mplier = '0;

      unique case (state_ff)
         bpcs_pkg::ST_IDLE: begin
            if (req_accept) begin
               d1_in          = d1_raw;
               dt_in          = dt_calc;
               mul_req.start  = 1'b1;
               mul_req.mcand  = PROD_W'(dt_calc);
               mul_req.mplier = bpcs_pkg::MPLIER_W'(c6_ff);
               state_in       = bpcs_pkg::ST_TEMP;
            end
         end
         bpcs_pkg::ST_TEMP: begin
            if (mul_rsp.done) begin
               priority if (temp_sum < bpcs_pkg::TEMP_MIN) begin
                  temp_in = bpcs_pkg::TEMP_W'(bpcs_pkg::TEMP_MIN);
               end else if (temp_sum > bpcs_pkg::TEMP_MAX) begin
                  temp_in = bpcs_pkg::TEMP_W'(bpcs_pkg::TEMP_MAX);
               end else begin
                  temp_in = bpcs_pkg::TEMP_W'(temp_sum);
               end
               mul_req.start  = 1'b1;
               mul_req.mplier = bpcs_pkg::MPLIER_W'(c4_ff);
               state_in       = bpcs_pkg::ST_OFF;
            end
         end
         bpcs_pkg::ST_OFF: begin
            if (mul_rsp.done) begin
               off_in = bpcs_pkg::OFF_W'(signed'({1'b0, c2_ff, 16'd0}))
                      + bpcs_pkg::OFF_W'(mul_rsp.prod >>> bpcs_pkg::SH_OFF);
               mul_req.start  = 1'b1;
               mul_req.mplier = bpcs_pkg::MPLIER_W'(c3_ff);
               state_in       = bpcs_pkg::ST_SENS;
            end
         end
         bpcs_pkg::ST_SENS: begin
            if (mul_rsp.done) begin
               mul_req.start  = 1'b1;
               mul_req.mcand  = PROD_W'(sens_calc);
               mul_req.mplier = d1_ff;
               state_in       = bpcs_pkg::ST_PRESS;
            end
         end
         bpcs_pkg::ST_PRESS: begin
            if (mul_rsp.done) begin
               p_in     = bpcs_pkg::P_W'(p_wide >>> bpcs_pkg::SH_FINAL);
               state_in = bpcs_pkg::ST_OUT;
            end
         end
         bpcs_pkg::ST_OUT: begin
            // Wait until the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_tready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, smooth_out.settled, temp_ff, smooth_out.start,
                               smooth_out.smooth, smooth_out.comp};
               state_in     = bpcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bpcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpcs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d1_ff       <= d1_in;
      dt_ff       <= dt_in;
      temp_ff     <= temp_in;
      off_ff      <= off_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A finished product only ever arrives while a compensation phase waits for it.
   assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff != bpcs_pkg::ST_IDLE && state_ff != bpcs_pkg::ST_OUT))
      else $error("multiplier finished outside a compensation phase");

   // The shared multiplier is free whenever a new item can be accepted.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpcs_pkg::ST_IDLE) |-> !mul_rsp.busy)
      else $error("multiplier busy while idle");

   // A result still waiting to be taken is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpcs_pkg::ST_OUT && rsp_valid_ff && !rsp_tready)
         |=> (state_ff == bpcs_pkg::ST_OUT))
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

@@ tb/baro_result_checker.sv @@
// Checker that predicts and compares the results of the barometer compensation core.
`timescale 1ns / 1ps

module baro_result_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [bpcs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [bpcs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [bpcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bpcs_pkg::COEF_W-1:0]     csr_data,
   output int                                   failures,
   output int                                   expected_count
);

   import bpcs_pkg::*;

   localparam longint PRESS_CEIL  = 131071;
   localparam longint TEMP_FLOOR  = -4000;
   localparam longint TEMP_CEIL   = 8500;
   localparam longint TEMP_OFFSET = 2000;

   // Same bit order as the result stream, settled in the top bit.
   typedef struct packed {
      logic                      settled;
      logic signed [TEMP_W-1:0]  temp_centi;
      logic [PRESS_W-1:0]        press_start;
      logic [PRESS_W-1:0]        press_smooth;
      logic [PRESS_W-1:0]        press_comp;
   } baro_result_type;

   localparam int RESULT_W = $bits(baro_result_type);

   logic [COEF_W-1:0]  sens_coef;
   logic [COEF_W-1:0]  offset_coef;
   logic [COEF_W-1:0]  sens_tc_coef;
   logic [COEF_W-1:0]  offset_tc_coef;
   logic [COEF_W-1:0]  tref_coef;
   logic [COEF_W-1:0]  tsens_coef;
   logic [WARM_W-1:0]  warmup_len;

   logic [PRESS_W-1:0] smooth_acc;
   logic [PRESS_W-1:0] start_ref;
   logic [WARM_W-1:0]  warm_seen;
   logic               is_settled;

   baro_result_type expected_readings[$];

   // Exact first-order compensation; >>> on signed 64-bit values floors.
   function automatic baro_result_type compensate_reading(input logic [IN_W-1:0] raw_press,
                                                          input logic [IN_W-1:0] raw_temp);
      longint        d1;
      longint        d2;
      longint        dt;
      longint        temp;
      longint        off;
      longint        sens;
      longint        press;
      logic [PRESS_W-1:0] comp;
      int unsigned   blend;
      baro_result_type r;
      d1    = longint'(raw_press & ADC_MASK);
      d2    = longint'(raw_temp & ADC_MASK);
      dt    = d2 - (longint'(tref_coef) <<< 8);
      temp  = TEMP_OFFSET + ((dt * longint'(tsens_coef)) >>> 23);
      off   = (longint'(offset_coef) <<< 16) + ((longint'(offset_tc_coef) * dt) >>> 7);
      sens  = (longint'(sens_coef) <<< 15) + ((longint'(sens_tc_coef) * dt) >>> 8);
      press = (((d1 * sens) >>> 21) - off) >>> 15;

      if (press < 0) begin
         comp = '0;
      end else if (press > PRESS_CEIL) begin
         comp = PRESS_W'(PRESS_CEIL);
      end else begin
         comp = PRESS_W'(press);
      end
      if (temp < TEMP_FLOOR) begin
         temp = TEMP_FLOOR;
      end else if (temp > TEMP_CEIL) begin
         temp = TEMP_CEIL;
      end

      blend = (32'(comp) + 32'd3 * 32'(smooth_acc)) >> 2;
      // Once settled, a larger warm-up length no longer reopens the warm-up.
      if (!is_settled && warm_seen < warmup_len) begin
         warm_seen  = warm_seen + 1'b1;
         smooth_acc = comp;
         start_ref  = comp;
      end else begin
         is_settled = 1'b1;
         smooth_acc = PRESS_W'(blend);
      end

      r.press_comp   = comp;
      r.press_smooth = smooth_acc;
      r.press_start  = start_ref;
      r.temp_centi   = TEMP_W'(temp);
      r.settled      = is_settled;
      return r;
   endfunction

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         failures++;
      end
   endtask

   task automatic compare_reading(input baro_result_type want,
                                  input logic [RSP_DATA_W-1:0] data);
      baro_result_type got;
      got = baro_result_type'(data[RESULT_W-1:0]);
      check_field("pressure_comp", want.press_comp, got.press_comp);
      check_field("pressure_smooth", want.press_smooth, got.press_smooth);
      check_field("pressure_start", want.press_start, got.press_start);
      check_field("temp_centi", longint'(want.temp_centi), longint'(got.temp_centi));
      check_field("settled", want.settled, got.settled);
      check_field("zero fill", 0, data[RSP_DATA_W-1:RESULT_W]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sens_coef      = RST_COEF_SENS;
         offset_coef    = RST_COEF_OFFSET;
         sens_tc_coef   = RST_COEF_SENS_TC;
         offset_tc_coef = RST_COEF_OFFSET_TC;
         tref_coef      = RST_COEF_TREF;
         tsens_coef     = RST_COEF_TSENS;
         warmup_len     = RST_WARMUP;
         smooth_acc     = '0;
         start_ref      = '0;
         warm_seen      = '0;
         is_settled     = 1'b0;
         expected_readings.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COEF_SENS:      sens_coef      = csr_data;
               CSR_COEF_OFFSET:    offset_coef    = csr_data;
               CSR_COEF_SENS_TC:   sens_tc_coef   = csr_data;
               CSR_COEF_OFFSET_TC: offset_tc_coef = csr_data;
               CSR_COEF_TREF:      tref_coef      = csr_data;
               CSR_COEF_TSENS:     tsens_coef     = csr_data;
               CSR_WARMUP:         warmup_len     = csr_data[WARM_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(
               compensate_reading(req_tdata[IN_W-1:0], req_tdata[2*IN_W-1:IN_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               $display("time %0t: result with none expected, expected nothing, actual 0x%h",
                        $time, rsp_tdata);
               failures++;
            end else begin
               compare_reading(expected_readings.pop_front(), rsp_tdata);
            end
         end
      end
      expected_count = expected_readings.size();
   end

endmodule

@@ tb/tb_top.sv @@
// Stimulus and verdict for the barometer compensation and smoothing core.
`timescale 1ns / 1ps

module tb_top;

   import bpcs_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;  // no register behind this index
   localparam logic [IN_W-1:0]      RAW_MAX   = '1;
   localparam logic [IN_W-1:0]      TYP_PRESS = 24'd9085466;
   localparam logic [IN_W-1:0]      TYP_TEMP  = 24'd8569150;
   localparam int                   HOLD_CYCLES = 300;
   localparam int                   NUM_DIRECTED = 16;

   logic                   clock;
   logic                   reset;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [COEF_W-1:0]      csr_data;
   int                     failures;
   int                     expected_count;
   bit                     steady_flow;
   bit                     rsp_hold_req;

   // Corners with the reset coefficients: zero and full scale, clamped
   // temperatures, dT of zero and minus one, alternating bit patterns.
   logic [IN_W-1:0] dir_press [NUM_DIRECTED] = '{
      24'd0, RAW_MAX, 24'd0, RAW_MAX, TYP_PRESS, TYP_PRESS, TYP_PRESS, 24'd1,
      24'h800000, TYP_PRESS, TYP_PRESS, 24'hAAAAAA, 24'h555555, 24'd11500000,
      24'd3000000, TYP_PRESS};
   logic [IN_W-1:0] dir_temp [NUM_DIRECTED] = '{
      24'd0, RAW_MAX, RAW_MAX, 24'd0, TYP_TEMP, 24'd0, RAW_MAX, 24'd1,
      24'h800000, 24'd8566784, 24'd8566783, 24'h555555, 24'hAAAAAA, TYP_TEMP,
      TYP_TEMP, TYP_TEMP};

   baro_pressure_compensate_smooth_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   baro_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .failures       (failures),
      .expected_count (expected_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off whenever it is requested.
   initial begin : rsp_sink
      int hold_left;
      bit calm;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         calm = steady_flow;
         if (hold_left == 0 && rsp_hold_req) begin
            hold_left = HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 19);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the handshake.
   task automatic push_pair(input logic [IN_W-1:0] raw_press, input logic [IN_W-1:0] raw_temp);
      while (!steady_flow && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {raw_temp, raw_press};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_coefs(input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2,
                             input logic [COEF_W-1:0] c3, input logic [COEF_W-1:0] c4,
                             input logic [COEF_W-1:0] c5, input logic [COEF_W-1:0] c6);
      write_csr(CSR_COEF_SENS, c1);
      write_csr(CSR_COEF_OFFSET, c2);
      write_csr(CSR_COEF_SENS_TC, c3);
      write_csr(CSR_COEF_OFFSET_TC, c4);
      write_csr(CSR_COEF_TREF, c5);
      write_csr(CSR_COEF_TSENS, c6);
   endtask

   // Mostly plausible sensor readings, the rest anywhere in the 24-bit range.
   function automatic logic [IN_W-1:0] draw_raw(input int unsigned lo, input int unsigned hi);
      if ($urandom_range(99) < 40) begin
         return IN_W'($urandom());
      end
      return IN_W'($urandom_range(hi, lo));
   endfunction

   function automatic logic [COEF_W-1:0] jitter(input logic [COEF_W-1:0] base);
      return base + COEF_W'($urandom_range(8000)) - COEF_W'(4000);
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         push_pair(draw_raw(3_000_000, 11_500_000), draw_raw(7_000_000, 9_800_000));
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic drain_results();
      int guard;
      guard = 0;
      while (expected_count != 0 && guard < 50000) begin
         @(negedge clock);
         guard++;
      end
      repeat (100) @(negedge clock);
   endtask

   initial begin : stimulus
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_COEF_SENS;
      csr_data     = '0;
      steady_flow  = 1'b0;
      rsp_hold_req = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The longest warm-up, written with the upper data bits set so they must be dropped.
      write_csr(CSR_WARMUP, 16'hFFFF);
      write_csr(CSR_SPARE, 16'h1234);
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         push_pair(dir_press[i], dir_temp[i]);
      end
      req_tvalid <= 1'b0;
      drain_results();

      load_coefs('0, '0, '0, '0, '0, '0);
      send_random(10);
      drain_results();
      load_coefs('1, '1, '1, '1, '1, '1);
      send_random(10);
      drain_results();

      // Warm-up ends during phase five; the later warm-up writes must not reopen it.
      for (int ph = 0; ph < 17; ph++) begin
         if (ph % 3 == 2) begin
            load_coefs(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
                       COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()));
         end else begin
            load_coefs(jitter(RST_COEF_SENS), jitter(RST_COEF_OFFSET),
                       jitter(RST_COEF_SENS_TC), jitter(RST_COEF_OFFSET_TC),
                       jitter(RST_COEF_TREF), jitter(RST_COEF_TSENS));
         end
         if (ph == 6) begin
            write_csr(CSR_WARMUP, 16'h0000);
         end else if (ph == 7) begin
            write_csr(CSR_WARMUP, {8'($urandom()), 8'd254});
         end else if (ph > 7) begin
            write_csr(CSR_WARMUP, COEF_W'($urandom_range(254)));
         end
         if (ph % 5 == 1) begin
            write_csr(CSR_SPARE, COEF_W'($urandom()));
         end
         steady_flow  = (ph == 9);
         rsp_hold_req = (ph == 4 || ph == 12);
         send_random(40);
         drain_results();
      end

      if (failures == 0 && expected_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bpcs_pkg.sv
rtl/bpcs_serial_mul.sv
rtl/bpcs_smooth.sv
rtl/baro_pressure_compensate_smooth_core.sv
tb/baro_result_checker.sv
tb/tb_top.sv
